// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  localparam longint unsigned MAX_STRING_BYTES = 64'd65535;
  // The byte counter and the consumed field are 16 bits, so the limit caps there.
  localparam logic [15:0] LEN_LIMIT =
    (MAX_STRING_BYTES > 64'd65535) ? 16'hFFFF : 16'(MAX_STRING_BYTES);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_TEXT,
    PH_ESC,
    PH_HEX_HI,
    PH_WANT_BS,
    PH_WANT_U,
    PH_HEX_LO,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_OK,
    TERM_FAIL
  } term_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  // Results caused by one input item: content bytes first, then an optional end mark.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    term_t           term;
    logic [15:0]     consumed;
  } rec_t;

endpackage

// ===== rtl/jsu_front.sv =====
// Parser front end: accepts input items and builds the result record of each item.
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic       in_start_flag,
  input  logic       in_end_flag,
  output logic       push,
  output rec_t       rec
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CC_BS     = 8'h08;
  localparam logic [7:0] CC_FF     = 8'h0C;
  localparam logic [7:0] CC_LF     = 8'h0A;
  localparam logic [7:0] CC_CR     = 8'h0D;
  localparam logic [7:0] CC_TAB    = 8'h09;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } unit_enc_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] high_unit_r, high_unit_nxt;
  logic [15:0] low_unit_r, low_unit_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;

  logic        active;
  logic        over;
  logic [15:0] bc_cur;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic        hex_last;
  logic [15:0] hi_shift;
  logic [15:0] lo_shift;
  logic [20:0] full_cp;
  unit_enc_t   hi_enc;
  rec_t        rec_c;

  function automatic unit_enc_t enc_unit(input logic [15:0] cp);
    unit_enc_t e;
    e = '0;
    if (cp < 16'h0080) begin
      e.b[0] = cp[7:0];
      e.n    = 3'd1;
    end else if (cp < 16'h0800) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.n    = 3'd2;
    end else begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.n    = 3'd3;
    end
    return e;
  endfunction

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      hex_d = in_byte[3:0];
    end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_d = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign active   = in_start_flag || ((phase_r != PH_IDLE) && (phase_r != PH_DONE));
  assign bc_cur   = in_start_flag ? 16'd0 : byte_count_r;
  assign over     = (bc_cur >= LEN_LIMIT);
  assign hex_last = (hex_count_r == 2'd3);
  assign hi_shift = {high_unit_r[11:0], hex_d};
  assign lo_shift = {low_unit_r[11:0], hex_d};
  assign full_cp  = {1'b0, high_unit_r[9:0], lo_shift[9:0]} + SUPP_BASE;
  assign hi_enc   = enc_unit(hi_shift);

  // Result record of the current item
  always_comb begin
    term_t t;
    rec_c = '0;
    t     = TERM_NONE;
    if (over) begin
      t = TERM_FAIL;
    end else if (in_start_flag) begin
      if (in_byte != CH_QUOTE) t = TERM_FAIL;
    end else begin
      case (phase_r)
        PH_TEXT: begin
          if (in_byte == CH_QUOTE) begin
            t = TERM_OK;
          end else if (in_byte != CH_BSLASH) begin
            rec_c.bytes[0] = in_byte;
            rec_c.nbytes   = 3'd1;
          end
        end
        PH_ESC: begin
          rec_c.nbytes = 3'd1;
          case (in_byte)
            CH_QUOTE:  rec_c.bytes[0] = CH_QUOTE;
            CH_BSLASH: rec_c.bytes[0] = CH_BSLASH;
            CH_SLASH:  rec_c.bytes[0] = CH_SLASH;
            CH_B:      rec_c.bytes[0] = CC_BS;
            CH_F:      rec_c.bytes[0] = CC_FF;
            CH_N:      rec_c.bytes[0] = CC_LF;
            CH_R:      rec_c.bytes[0] = CC_CR;
            CH_T:      rec_c.bytes[0] = CC_TAB;
            CH_U:      rec_c.nbytes   = 3'd0;
            default: begin
              rec_c.nbytes = 3'd0;
              t            = TERM_FAIL;
            end
          endcase
        end
        PH_HEX_HI: begin
          if (!hex_ok) begin
            t = TERM_FAIL;
          end else if (hex_last && !(hi_shift inside {[SURR_HI_MIN:SURR_HI_MAX]})) begin
            rec_c.bytes  = hi_enc.b;
            rec_c.nbytes = hi_enc.n;
          end
        end
        PH_WANT_BS: begin
          if (in_byte != CH_BSLASH) t = TERM_FAIL;
        end
        PH_WANT_U: begin
          if (in_byte != CH_U) t = TERM_FAIL;
        end
        PH_HEX_LO: begin
          if (!hex_ok) begin
            t = TERM_FAIL;
          end else if (hex_last) begin
            if (!(lo_shift inside {[SURR_LO_MIN:SURR_LO_MAX]})) begin
              t = TERM_FAIL;
            end else begin
              rec_c.bytes[0] = {5'b11110, full_cp[20:18]};
              rec_c.bytes[1] = {2'b10, full_cp[17:12]};
              rec_c.bytes[2] = {2'b10, full_cp[11:6]};
              rec_c.bytes[3] = {2'b10, full_cp[5:0]};
              rec_c.nbytes   = 3'd4;
            end
          end
        end
        default: ;
      endcase
    end
    // Input ran out before the string closed
    if (t == TERM_NONE && in_end_flag) t = TERM_FAIL;
    rec_c.term = t;
    if (t == TERM_OK) rec_c.consumed = bc_cur + 16'd1;
  end

  // Parser next state
  always_comb begin
    phase_nxt      = phase_r;
    high_unit_nxt  = high_unit_r;
    low_unit_nxt   = low_unit_r;
    hex_count_nxt  = hex_count_r;
    byte_count_nxt = byte_count_r;
    if (acc && active) begin
      if (in_start_flag) begin
        phase_nxt     = PH_TEXT;
        high_unit_nxt = '0;
        low_unit_nxt  = '0;
        hex_count_nxt = '0;
      end
      if (!over) begin
        byte_count_nxt = bc_cur + 16'd1;
        if (!in_start_flag) begin
          case (phase_r)
            PH_TEXT: begin
              if (in_byte == CH_BSLASH) phase_nxt = PH_ESC;
            end
            PH_ESC: begin
              phase_nxt = PH_TEXT;
              if (in_byte == CH_U) begin
                high_unit_nxt = '0;
                hex_count_nxt = '0;
                phase_nxt     = PH_HEX_HI;
              end
            end
            PH_HEX_HI: begin
              if (hex_ok) begin
                high_unit_nxt = hi_shift;
                if (hex_last) begin
                  hex_count_nxt = '0;
                  phase_nxt = (hi_shift inside {[SURR_HI_MIN:SURR_HI_MAX]}) ?
                              PH_WANT_BS : PH_TEXT;
                end else begin
                  hex_count_nxt = hex_count_r + 2'd1;
                end
              end
            end
            PH_WANT_BS: begin
              if (in_byte == CH_BSLASH) phase_nxt = PH_WANT_U;
            end
            PH_WANT_U: begin
              if (in_byte == CH_U) begin
                low_unit_nxt  = '0;
                hex_count_nxt = '0;
                phase_nxt     = PH_HEX_LO;
              end
            end
            PH_HEX_LO: begin
              if (hex_ok) begin
                low_unit_nxt = lo_shift;
                if (hex_last) begin
                  hex_count_nxt = '0;
                  phase_nxt     = PH_TEXT;
                end else begin
                  hex_count_nxt = hex_count_r + 2'd1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      // Any end mark, success or failure, closes the string
      if (rec_c.term != TERM_NONE) phase_nxt = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      high_unit_r  <= '0;
      low_unit_r   <= '0;
      hex_count_r  <= '0;
      byte_count_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      high_unit_r  <= high_unit_nxt;
      low_unit_r   <= low_unit_nxt;
      hex_count_r  <= hex_count_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

  assign push = acc && active && ((rec_c.nbytes != 3'd0) || (rec_c.term != TERM_NONE));
  assign rec  = rec_c;

endmodule

// ===== rtl/jsu_queue.sv =====
// Short queue of result records between parser and output sequencer.
module jsu_queue import jsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output rec_t head_rec
);

  rec_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = (count_r == QCW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_rec   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + QCW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
// Output sequencer: walks the results of each queued record into the output register.
module jsu_back import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  rec_t        head_rec,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic [15:0] out_consumed,
  output logic        out_last_of_run
);

  logic [2:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r;
  kind_t       kind_r;
  logic [15:0] consumed_r;
  logic        last_r;

  logic        load;
  logic [2:0]  total;
  logic        is_last;
  logic        in_bytes;
  logic [7:0]  sel_byte;
  kind_t       sel_kind;
  logic [15:0] sel_consumed;

  assign total    = head_rec.nbytes + {2'b00, (head_rec.term != TERM_NONE)};
  assign is_last  = (idx_r == total - 3'd1);
  assign in_bytes = (idx_r < head_rec.nbytes);
  assign load     = head_valid && (!out_valid_r || !out_stall);
  assign pop      = load && is_last;

  always_comb begin
    sel_byte     = '0;
    sel_kind     = KIND_BYTE;
    sel_consumed = '0;
    if (in_bytes) begin
      sel_byte = head_rec.bytes[idx_r[1:0]];
    end else begin
      case (head_rec.term)
        TERM_OK: begin
          sel_kind     = KIND_OK;
          sel_consumed = head_rec.consumed;
        end
        TERM_FAIL: sel_kind = KIND_FAIL;
        default:   sel_kind = KIND_BYTE;
      endcase
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 3'd0 : idx_r + 3'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while the consumer stalls
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= sel_byte;
      kind_r     <= sel_kind;
      consumed_r <= sel_consumed;
      last_r     <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_kind        = kind_r;
  assign out_consumed    = consumed_r;
  assign out_last_of_run = last_r;

endmodule

// ===== rtl/json_string_unescape.sv =====
// The results of an accepted item are written into the queue, then into the output register.
// Throughput: one input item per cycle while the 4-record queue has room; the output
// sequencer sends one result per cycle while out_stall is low, so an item's k results leave in order.
// Reset (synchronous, rst_n low): parser idle awaiting a start byte, queue empty,
// no result valid.
module json_string_unescape import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_start_flag,
  input  logic        in_end_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic [15:0] out_consumed,
  output logic        out_last_of_run
);

  logic acc;
  logic push;
  rec_t push_rec;
  logic full;
  logic pop;
  logic head_valid;
  rec_t head_rec;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  jsu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .in_byte       (in_byte),
    .in_start_flag (in_start_flag),
    .in_end_flag   (in_end_flag),
    .push          (push),
    .rec           (push_rec)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_rec        (head_rec),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_consumed    (out_consumed),
    .out_last_of_run (out_last_of_run)
  );

endmodule
